@@ hdl/packet_crc_ack_checker_top_defines.svh @@
// Assertion macros used by the checker's top-level RTL file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PACKET_CRC_ACK_CHECKER_TOP_DEFINES_SVH
`define PACKET_CRC_ACK_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pcac_pkg.sv @@
package pcac_pkg;

  // Width of the payload byte counter; it covers the largest payload limit.
  localparam int CNT_W = 11;

  // CRC-32, reflected form.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Header type codes.
  localparam logic [7:0] TYPE_INIT = 8'd4;
  localparam logic [7:0] TYPE_MSG  = 8'd10;
  localparam logic [7:0] TYPE_END  = 8'd16;

  // Reply codes.
  localparam logic REPLY_ACK    = 1'b0;
  localparam logic REPLY_RESEND = 1'b1;

  // One input beat.
  typedef struct packed {
    logic signed [15:0] pkt_number;
    logic [7:0]         pkt_type;
    logic [31:0]        crc_field;
    logic [7:0]         data_byte;
    logic               has_byte;
    logic               last_item;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic        reply_code;
    logic [31:0] computed_crc;
  } out_item_t;

  // Control handed from the top level to the stage modules.
  typedef struct packed {
    logic advance;
    logic last_item;
  } step_ctl_t;

  // Folds one byte into the reflected CRC register, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hdl/packet_crc_ack_checker_top.sv @@
// Packet CRC-32 checker with ACK / resend replies.
// Input channel (in_valid, in_stall, in_data): one beat per packet item, carrying
// the header, an optional payload byte and a last-item mark. Result channel
// (out_valid, out_stall, out_data): at most one reply per packet, issued for the
// last beat of a packet with a positive number and type 4, 10 or 16.
// A beat is held in the input register, then the CRC update and reply decision
// run in one byte-wide pass into the result register.
// Throughput: one beat per cycle while the result register can take a reply;
// the input register takes a new beat while the result register still holds one.
// When the receiver stalls with a reply pending, the input register stops
// advancing and in_stall rises once it is occupied; beats that give no reply
// are also held, so ordering stays intact.
// Reset (rst_n low, synchronous) empties both registers and restarts the CRC.
`include "packet_crc_ack_checker_top_defines.svh"
module packet_crc_ack_checker_top
  import pcac_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 1451
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        in_valid_r;
  in_item_t    in_r;
  logic        out_free;
  logic        advance;
  logic        last_adv;
  logic [31:0] final_crc;
  step_ctl_t   ctl;

  // The held beat moves on whenever the result register can take a reply.
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  // A last beat moves on this cycle.
  assign last_adv = advance && in_r.last_item;

  assign ctl.advance   = advance;
  assign ctl.last_item = in_r.last_item;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Running CRC over the packet's payload.
  pcac_crc_unit #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_crc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (in_r.data_byte),
    .has_byte  (in_r.has_byte),
    .final_crc (final_crc)
  );

  // Reply decision and result register.
  pcac_reply u_reply (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .item      (in_r),
    .final_crc (final_crc),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Back-pressure at the input only ever comes from a stalled pending reply.
  `PCAC_ASSERT_NOW(a_stall_from_output, in_stall, out_valid && out_stall, "stray in_stall")

  // A new reply appears only after a last beat has moved through.
  `PCAC_ASSERT_NOW(a_reply_from_last, $rose(out_valid), $past(last_adv), "no last beat")

  // A beat accepted on top of a held one means the held one advanced.
  `PCAC_ASSERT_NOW(a_no_overwrite, in_valid && !in_stall && in_valid_r, advance, "beat lost")

  // A drained result register never shows stale data without a new reply.
  `PCAC_ASSERT_NEXT(a_drain, out_valid && !out_stall && !last_adv, !out_valid, "reply repeated")

endmodule

@@ hdl/pcac_crc_unit.sv @@
module pcac_crc_unit
  import pcac_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 1451
) (
  input  logic        clk,
  input  logic        rst_n,
  input  step_ctl_t   ctl,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  output logic [31:0] final_crc
);

  logic [31:0]      crc_r;
  logic [31:0]      crc_nxt;
  logic             zero_r;
  logic             zero_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             take;

  // A byte is taken until a zero byte or the payload limit ends the CRC.
  assign take = has_byte && !zero_r && (count_r < CNT_W'(PAYLOAD_BYTES));

  // Fold the current beat's byte into the running CRC.
  always_comb begin
    crc_nxt   = crc_r;
    zero_nxt  = zero_r;
    count_nxt = count_r;
    if (take) begin
      if (data_byte == 8'd0) begin
        zero_nxt = 1'b1;
      end else begin
        crc_nxt   = crc_byte(crc_r, data_byte);
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // The reply sees the CRC including a byte carried on the last beat.
  assign final_crc = ~crc_nxt;

  // Packet state; it returns to its initial values after every last beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      zero_r  <= 1'b0;
      count_r <= '0;
    end else if (ctl.advance) begin
      if (ctl.last_item) begin
        crc_r   <= CRC_INIT;
        zero_r  <= 1'b0;
        count_r <= '0;
      end else begin
        crc_r   <= crc_nxt;
        zero_r  <= zero_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

@@ hdl/pcac_reply.sv @@
module pcac_reply
  import pcac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  step_ctl_t   ctl,
  input  in_item_t    item,
  input  logic [31:0] final_crc,
  input  logic        out_stall,
  output logic        out_free,
  output logic        out_valid,
  output out_item_t   out_data
);

  logic      answer;
  logic      positive;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t reply_nxt;

  // Only packets with a strictly positive number are answered.
  assign positive = !item.pkt_number[15] && (item.pkt_number != 16'sd0);

  // Decide on the reply from the last beat's header.
  always_comb begin
    answer                 = 1'b0;
    reply_nxt.reply_code   = REPLY_ACK;
    reply_nxt.computed_crc = final_crc;
    case (item.pkt_type) inside
      TYPE_INIT, TYPE_END: begin
        answer = positive;
      end
      TYPE_MSG: begin
        answer = positive;
        reply_nxt.reply_code = (item.crc_field == final_crc) ? REPLY_ACK : REPLY_RESEND;
      end
      default: begin
        answer = 1'b0;
      end
    endcase
  end

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.advance && ctl.last_item && answer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.last_item && answer) begin
      out_data_r <= reply_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sv/pcac_reply_checker.sv @@
// CRC helper shared by the reply checker and the packet generator.
package pcac_crc_pkg;
  import pcac_pkg::CRC_POLY;

  // Folds one payload byte into a reflected CRC-32 register, LSB first.
  function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc ^ {24'h0, b};
    repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    return r;
  endfunction

endpackage

// Watches both channels, works out the reply each packet should get and
// compares every reply beat against the oldest one still outstanding.
module pcac_reply_checker
  import pcac_pkg::*;
  import pcac_crc_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 1451
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  // Running packet state, mirrored from the input beats.
  logic [31:0]      crc_run;
  logic             zero_hit;
  logic [CNT_W-1:0] bytes_taken;

  // Replies owed by the block, oldest first.
  out_item_t        reply_q[$];
  int               mismatches = 0;

  // Folds one accepted beat into the packet state and queues the reply it causes.
  task automatic predict_reply(input in_item_t beat);
    out_item_t   want;
    logic [31:0] crc_out;
    if (beat.has_byte && !zero_hit && bytes_taken < PAYLOAD_BYTES) begin
      if (beat.data_byte == 8'h00) begin
        zero_hit = 1'b1;
      end else begin
        crc_run     = crc32_fold(crc_run, beat.data_byte);
        bytes_taken = bytes_taken + 1'b1;
      end
    end
    if (beat.last_item) begin
      crc_out           = ~crc_run;
      want.computed_crc = crc_out;
      if ($signed(beat.pkt_number) > 16'sd0) begin
        if (beat.pkt_type == TYPE_INIT || beat.pkt_type == TYPE_END) begin
          want.reply_code = REPLY_ACK;
          reply_q.push_back(want);
        end else if (beat.pkt_type == TYPE_MSG) begin
          want.reply_code = (beat.crc_field == crc_out) ? REPLY_ACK : REPLY_RESEND;
          reply_q.push_back(want);
        end
      end
      // Every last beat starts the next packet afresh.
      crc_run     = CRC_INIT;
      zero_hit    = 1'b0;
      bytes_taken = '0;
    end
  endtask

  // Sample both channels at each rising edge.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      crc_run     = CRC_INIT;
      zero_hit    = 1'b0;
      bytes_taken = '0;
      reply_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_reply(in_data);
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: reply with none owed: expected none, actual code %0b crc %08h",
                   $time, out_data.reply_code, out_data.computed_crc);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (out_data.reply_code !== want.reply_code) begin
            $display("%0t: reply_code mismatch: expected %0b, actual %0b",
                     $time, want.reply_code, out_data.reply_code);
            mismatches++;
          end
          if (out_data.computed_crc !== want.computed_crc) begin
            $display("%0t: computed_crc mismatch: expected %08h, actual %08h",
                     $time, want.computed_crc, out_data.computed_crc);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= reply_q.size();
  end

endmodule

@@ tb/sv/packet_crc_ack_checker_top_tb.sv @@
// Drives packets into the CRC checker and gives the verdict; the reply
// checker beside the block does the prediction and comparison.
module packet_crc_ack_checker_top_tb;
  import pcac_pkg::*;
  import pcac_crc_pkg::*;

  localparam int PAYLOAD_BYTES = 1451;
  localparam int RANDOM_BEATS  = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int TAIL_CYCLES   = 8;

  // Receiver stall patterns.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int pending;
  int burst_left;
  int beats_sent;
  int holds_asked;
  int idle_cycles;

  packet_crc_ack_checker_top #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  pcac_reply_checker #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Clock with a period of 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run if neither channel moves a beat for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[packet_crc_ack_checker_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: changes stall pattern now and then, and serves long hold-offs on request.
  initial begin : receiver
    rx_mode_e mode;
    int       mode_left;
    int       period;
    int       tick;
    int       holds_done;
    out_stall  = 1'b0;
    mode       = RX_FREE;
    mode_left  = 0;
    period     = 1;
    tick       = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done < holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(3, 0));
        mode_left = $urandom_range(256, 32);
        period    = $urandom_range(8, 1);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(3, 0) != 0);
        default:  out_stall <= ((tick / period) % 2 == 1);
      endcase
    end
  end

  // A beat with random header fields and no payload byte.
  function automatic in_item_t noise_beat();
    in_item_t b;
    b.pkt_number = 16'($urandom);
    b.pkt_type   = 8'($urandom);
    b.crc_field  = $urandom;
    b.data_byte  = 8'($urandom);
    b.has_byte   = 1'b0;
    b.last_item  = 1'b0;
    return b;
  endfunction

  // Offers one beat and waits for it to be taken; ends a burst with a random gap.
  task automatic send_beat(input in_item_t beat);
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                               : $urandom_range(40, 1);
    end
  endtask

  // Sends one packet: nbytes payload beats (a zero at index zero_at, if any),
  // optionally a header-only last beat, and optionally header-only fillers.
  task automatic send_packet(input logic signed [15:0] num, input logic [7:0] ptype,
                             input int nbytes, input int zero_at, input bit crc_ok,
                             input bit tail_hdr, input bit fillers);
    in_item_t    beat;
    logic [31:0] acc;
    logic [31:0] flip;
    bit          stopped;
    int          taken;
    acc     = CRC_INIT;
    stopped = 1'b0;
    taken   = 0;
    for (int i = 0; i < nbytes; i++) begin
      if (fillers && $urandom_range(7, 0) == 0) begin
        send_beat(noise_beat());
      end
      beat           = noise_beat();
      beat.has_byte  = 1'b1;
      beat.data_byte = (i == zero_at) ? 8'h00 : 8'($urandom_range(255, 1));
      if (!stopped && taken < PAYLOAD_BYTES) begin
        if (beat.data_byte == 8'h00) begin
          stopped = 1'b1;
        end else begin
          acc = crc32_fold(acc, beat.data_byte);
          taken++;
        end
      end
      if (i != nbytes - 1 || tail_hdr) begin
        send_beat(beat);
      end
    end
    // The last beat carries the header that decides the reply.
    if (nbytes == 0 || tail_hdr) begin
      beat = noise_beat();
    end
    flip = ($urandom_range(1, 0) == 0) ? (32'h1 << $urandom_range(31, 0)) : ($urandom | 32'h1);
    beat.pkt_number = num;
    beat.pkt_type   = ptype;
    beat.crc_field  = crc_ok ? ~acc : (~acc ^ flip);
    beat.last_item  = 1'b1;
    send_beat(beat);
  endtask

  // A random packet: mostly answered types and positive numbers, short payloads.
  task automatic send_random_packet();
    logic signed [15:0] num;
    logic [7:0]         ptype;
    int                 pick;
    int                 nbytes;
    int                 zero_at;
    pick = $urandom_range(9, 0);
    if (pick < 7) num = 16'($urandom_range(32767, 1));
    else if (pick == 7) num = 16'sd0;
    else num = {1'b1, 15'($urandom_range(32767, 0))};
    pick = $urandom_range(9, 0);
    if (pick < 4) ptype = TYPE_MSG;
    else if (pick < 6) ptype = TYPE_INIT;
    else if (pick < 8) ptype = TYPE_END;
    else ptype = 8'($urandom);
    nbytes  = ($urandom_range(15, 0) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
    zero_at = ($urandom_range(4, 0) == 0) ? $urandom_range(nbytes, 0) : -1;
    send_packet(num, ptype, nbytes, zero_at, $urandom_range(2, 0) != 0,
                $urandom_range(3, 0) == 0, 1'b1);
  endtask

  // Holds the sender back until every owed reply has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int  start;
    bit  held;
    bit  drained;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    holds_asked = 0;
    beats_sent  = 0;
    burst_left  = $urandom_range(40, 1);
    held        = 1'b0;
    drained     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets.
    send_packet(16'sd1, TYPE_INIT, 0, -1, 1'b1, 1'b1, 1'b0);      // empty payload
    send_packet(16'sd32767, TYPE_END, 2, -1, 1'b0, 1'b0, 1'b0);   // largest number, byte on last
    send_packet(16'sd7, TYPE_MSG, 3, -1, 1'b1, 1'b0, 1'b0);       // matching CRC
    send_packet(16'sd8, TYPE_MSG, 2, -1, 1'b0, 1'b1, 1'b0);       // wrong CRC
    send_packet(16'sd2, TYPE_MSG, 4, 1, 1'b1, 1'b0, 1'b0);        // zero byte mid-packet
    send_packet(16'sd3, TYPE_MSG, 2, 1, 1'b1, 1'b0, 1'b0);        // zero byte on last beat
    send_packet(16'sd0, TYPE_INIT, 1, -1, 1'b1, 1'b0, 1'b0);      // number zero
    send_packet(-16'sd32768, TYPE_MSG, 1, -1, 1'b1, 1'b0, 1'b0);  // most negative number
    send_packet(-16'sd1, TYPE_END, 0, -1, 1'b1, 1'b1, 1'b0);
    send_packet(16'sd9, 8'd11, 1, -1, 1'b1, 1'b0, 1'b0);          // unanswered types
    send_packet(16'sd9, 8'd255, 0, -1, 1'b1, 1'b1, 1'b0);
    send_packet(16'sd9, 8'd0, 0, -1, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // Random packets, with one long receiver hold-off and one full drain.
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      if (!held && beats_sent - start > 80) begin
        holds_asked <= holds_asked + 1;
        held = 1'b1;
      end
      if (!drained && beats_sent - start > 180) begin
        wait_drained();
        drained = 1'b1;
      end
      send_random_packet();
    end

    // A payload past the size limit; the zero after the limit is ignored.
    send_packet(16'sd100, TYPE_MSG, PAYLOAD_BYTES + 2, PAYLOAD_BYTES + 1, 1'b1, 1'b0, 1'b0);
    send_random_packet();

    // Let every owed reply arrive, then watch a few more cycles.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[packet_crc_ack_checker_top] OK");
    end else begin
      $display("[packet_crc_ack_checker_top] ERROR");
    end
    $finish;
  end

endmodule
